FILE: hw/rtl/periodic_lattice_current_stencil_unit_assert.svh
// ----------------------------------------------------------------------------
// periodic lattice current stencil - assertion macros
// shared property forms for the concurrent checks in the rtl
// ----------------------------------------------------------------------------
`ifndef PERIODIC_LATTICE_CURRENT_STENCIL_UNIT_ASSERT_SVH
`define PERIODIC_LATTICE_CURRENT_STENCIL_UNIT_ASSERT_SVH

// same-cycle implication
`define PLCS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PLCS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/plcs_pkg.sv
// ----------------------------------------------------------------------------
// plcs_pkg
// types and constants shared by the lattice current stencil unit
// ----------------------------------------------------------------------------
package plcs_pkg;

  localparam int SIDE_DEFAULT = 16;
  localparam int COORD_IN_W   = 4;
  localparam int DATA_W       = 16;
  localparam int WORD_W       = 2 * DATA_W;
  localparam int OUT_W        = 32;
  localparam int SCALE_W      = 32;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;
  localparam int NUM_LANES    = 3;

  // lane arithmetic widths
  localparam int DIFF_W = DATA_W + 1;
  localparam int PROD_W = DATA_W + DIFF_W;
  localparam int TERM_W = PROD_W + 1;
  localparam int SUM_W  = TERM_W + 2;
  localparam int MAG_W  = SUM_W - 1;

  // read sequence: centre, then plus/minus pairs along x, y, z
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_CENTRE = 3'd0;
  localparam logic [STEP_W-1:0] STEP_LAST   = 3'd6;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic [COORD_IN_W-1:0]    site_x;
    logic [COORD_IN_W-1:0]    site_y;
    logic [COORD_IN_W-1:0]    site_z;
    logic signed [DATA_W-1:0] comp0_re;
    logic signed [DATA_W-1:0] comp0_im;
    logic signed [DATA_W-1:0] comp1_re;
    logic signed [DATA_W-1:0] comp1_im;
    logic signed [DATA_W-1:0] comp2_re;
    logic signed [DATA_W-1:0] comp2_im;
  } item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] current_x;
    logic signed [OUT_W-1:0] current_y;
    logic signed [OUT_W-1:0] current_z;
  } result_t;

  // travels with the read data of the lattice memories
  typedef struct packed {
    logic              valid;
    logic [STEP_W-1:0] step;
  } rd_tag_t;

  // travels with a per-axis partial result
  typedef struct packed {
    logic  valid;
    axis_e axis;
  } axis_tag_t;

endpackage

FILE: hw/rtl/plcs_lane.sv
// ----------------------------------------------------------------------------
// plcs_lane
// one field component: lattice memory and per-axis im(conj(s) * (p - m))
// ----------------------------------------------------------------------------
module plcs_lane #(
  parameter int SIDE = plcs_pkg::SIDE_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic                                  rd_en,
  input  logic [$clog2(SIDE*SIDE*SIDE)-1:0]     addr,
  input  logic [plcs_pkg::WORD_W-1:0]           wr_data,
  input  plcs_pkg::rd_tag_t                     rd_tag,
  output logic signed [plcs_pkg::TERM_W-1:0]    term,
  output plcs_pkg::axis_tag_t                   term_tag
);

  localparam int Depth = SIDE * SIDE * SIDE;
  localparam int DW    = plcs_pkg::DATA_W;

  logic [plcs_pkg::WORD_W-1:0] mem [Depth];
  logic [plcs_pkg::WORD_W-1:0] rd_data;

  logic signed [DW-1:0] s_re, s_im, p_re, p_im;
  logic signed [DW-1:0] m_re, m_im;
  logic signed [plcs_pkg::DIFF_W-1:0] d_re, d_im;
  logic signed [plcs_pkg::PROD_W-1:0] prod_a, prod_b;
  plcs_pkg::axis_tag_t d_tag, p_tag;
  plcs_pkg::axis_e     step_axis;

  // single port: a load and a query read never share a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

  assign m_re = $signed(rd_data[plcs_pkg::WORD_W-1:DW]);
  assign m_im = $signed(rd_data[DW-1:0]);

  always_comb begin
    case (rd_tag.step)
      3'd2:    step_axis = plcs_pkg::AXIS_X;
      3'd4:    step_axis = plcs_pkg::AXIS_Y;
      default: step_axis = plcs_pkg::AXIS_Z;
    endcase
  end

  // centre on step 0, plus neighbour on odd steps, minus neighbour on even steps
  always_ff @(posedge clk) begin
    if (rd_tag.valid && rd_tag.step == plcs_pkg::STEP_CENTRE) begin
      s_re <= m_re;
      s_im <= m_im;
    end
    if (rd_tag.valid && rd_tag.step[0]) begin
      p_re <= m_re;
      p_im <= m_im;
    end
    d_re    <= plcs_pkg::DIFF_W'(p_re) - plcs_pkg::DIFF_W'(m_re);
    d_im    <= plcs_pkg::DIFF_W'(p_im) - plcs_pkg::DIFF_W'(m_im);
    prod_a  <= s_re * d_im;
    prod_b  <= s_im * d_re;
    term    <= plcs_pkg::TERM_W'(prod_a) - plcs_pkg::TERM_W'(prod_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_tag    <= '0;
      p_tag    <= '0;
      term_tag <= '0;
    end else begin
      d_tag.valid <= rd_tag.valid && rd_tag.step != plcs_pkg::STEP_CENTRE
                     && !rd_tag.step[0];
      d_tag.axis  <= step_axis;
      p_tag       <= d_tag;
      term_tag    <= p_tag;
    end
  end

endmodule

FILE: hw/rtl/plcs_seq.sv
// ----------------------------------------------------------------------------
// plcs_seq
// command decode and the seven-site read sequence over the lattice
// ----------------------------------------------------------------------------
`include "periodic_lattice_current_stencil_unit_assert.svh"

module plcs_seq #(
  parameter int SIDE = plcs_pkg::SIDE_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  plcs_pkg::item_t                   item,
  output logic                              busy,
  output logic                              mem_wr,
  output logic                              mem_rd,
  output logic [$clog2(SIDE*SIDE*SIDE)-1:0] mem_addr,
  output plcs_pkg::rd_tag_t                 rd_tag
);

  localparam int CW       = $clog2(SIDE);
  localparam int AW       = $clog2(SIDE * SIDE * SIDE);
  localparam int RedSteps = 15 / SIDE;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  state_e state;
  logic [plcs_pkg::STEP_W-1:0] step, issue_step;
  logic [CW-1:0] cx, cy, cz, xr, yr, zr;
  logic accept;

  function automatic logic [CW-1:0] reduce(input logic [plcs_pkg::COORD_IN_W-1:0] v);
    logic [6:0] t;
    t = 7'(v);
    for (int i = 0; i < RedSteps; i++) begin
      if (t >= 7'(SIDE)) begin
        t = t - 7'(SIDE);
      end
    end
    return t[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] inc(input logic [CW-1:0] v);
    return (v == CW'(SIDE - 1)) ? '0 : v + CW'(1);
  endfunction

  function automatic logic [CW-1:0] dec(input logic [CW-1:0] v);
    return (v == '0) ? CW'(SIDE - 1) : v - CW'(1);
  endfunction

  function automatic logic [AW-1:0] site_addr(input logic [CW-1:0] x,
                                              input logic [CW-1:0] y,
                                              input logic [CW-1:0] z);
    return (AW'(x) * AW'(SIDE) + AW'(y)) * AW'(SIDE) + AW'(z);
  endfunction

  assign busy   = (state == ST_READ);
  assign accept = start && !busy;
  assign xr     = reduce(item.site_x);
  assign yr     = reduce(item.site_y);
  assign zr     = reduce(item.site_z);

  assign mem_wr     = accept && item.cmd == plcs_pkg::CMD_LOAD;
  assign mem_rd     = (accept && item.cmd == plcs_pkg::CMD_QUERY) || busy;
  assign issue_step = busy ? step : plcs_pkg::STEP_CENTRE;

  always_comb begin
    if (!busy) begin
      mem_addr = site_addr(xr, yr, zr);
    end else begin
      case (step)
        3'd1:    mem_addr = site_addr(inc(cx), cy, cz);
        3'd2:    mem_addr = site_addr(dec(cx), cy, cz);
        3'd3:    mem_addr = site_addr(cx, inc(cy), cz);
        3'd4:    mem_addr = site_addr(cx, dec(cy), cz);
        3'd5:    mem_addr = site_addr(cx, cy, inc(cz));
        3'd6:    mem_addr = site_addr(cx, cy, dec(cz));
        default: mem_addr = site_addr(cx, cy, cz);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cx <= xr;
      cy <= yr;
      cz <= zr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      step   <= plcs_pkg::STEP_CENTRE;
      rd_tag <= '0;
    end else begin
      rd_tag.valid <= mem_rd;
      rd_tag.step  <= issue_step;
      case (state)
        ST_IDLE: begin
          if (accept && item.cmd == plcs_pkg::CMD_QUERY) begin
            state <= ST_READ;
            step  <= 3'd1;
          end
        end
        ST_READ: begin
          if (step == plcs_pkg::STEP_LAST) begin
            state <= ST_IDLE;
            step  <= plcs_pkg::STEP_CENTRE;
          end else begin
            step <= step + 3'd1;
          end
        end
        default: begin
          state <= ST_IDLE;
          step  <= plcs_pkg::STEP_CENTRE;
        end
      endcase
    end
  end

  `PLCS_ASSERT_NEXT(a_query_holds_busy, clk, rst, accept && item.cmd == plcs_pkg::CMD_QUERY, busy, "query accepted without starting the read sequence")
  `PLCS_ASSERT_NEXT(a_load_single_cycle, clk, rst, mem_wr, !busy, "load transaction left the sequencer busy")
  `PLCS_ASSERT_NOW(a_step_in_range, clk, rst, busy, step != plcs_pkg::STEP_CENTRE && step <= plcs_pkg::STEP_LAST, "read step out of range")
  `PLCS_ASSERT_NEXT(a_sequence_order, clk, rst, rd_tag.valid && rd_tag.step == plcs_pkg::STEP_LAST, !rd_tag.valid || rd_tag.step == plcs_pkg::STEP_CENTRE, "read after last neighbour is not a new centre")

endmodule

FILE: hw/rtl/plcs_merge.sv
// ----------------------------------------------------------------------------
// plcs_merge
// sums the lane terms, scales, rounds, saturates and gathers the three axes
// ----------------------------------------------------------------------------
`include "periodic_lattice_current_stencil_unit_assert.svh"

module plcs_merge (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [plcs_pkg::SCALE_W-1:0]       cfg_data,
  input  logic signed [plcs_pkg::TERM_W-1:0] term [plcs_pkg::NUM_LANES],
  input  plcs_pkg::axis_tag_t                term_tag [plcs_pkg::NUM_LANES],
  output logic                               done,
  output plcs_pkg::result_t                  result
);

  localparam int HALF_W  = plcs_pkg::SCALE_W / 2;
  localparam int MUL_W   = plcs_pkg::MAG_W + HALF_W;
  localparam int RW      = MUL_W + 1 - 15;
  localparam logic [MUL_W:0] RoundBias = (MUL_W + 1)'(64'd1 << 30);
  localparam logic [RW-1:0] PosMax = RW'(33'h0_7FFF_FFFF);
  localparam logic [RW-1:0] NegMin = RW'(33'h0_8000_0000);
  localparam int OW = plcs_pkg::OUT_W;

  logic [plcs_pkg::SCALE_W-1:0] scale;
  logic signed [plcs_pkg::SUM_W-1:0] sum;
  logic [plcs_pkg::MAG_W-1:0] mag;
  logic [MUL_W-1:0] pa, pb;
  logic neg_m, neg_p;
  plcs_pkg::axis_tag_t sum_tag, mag_tag, mul_tag;
  logic [MUL_W:0] bb, tot;
  logic [RW-1:0] r, nr;
  logic signed [OW-1:0] val, cur_x, cur_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= plcs_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      scale <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    sum   <= plcs_pkg::SUM_W'(term[0]) + plcs_pkg::SUM_W'(term[1])
             + plcs_pkg::SUM_W'(term[2]);
    neg_m <= sum[plcs_pkg::SUM_W-1];
    mag   <= plcs_pkg::MAG_W'(sum[plcs_pkg::SUM_W-1] ? -sum : sum);
    neg_p <= neg_m;
    // scale split in halves keeps each product near 35 x 16
    pa    <= MUL_W'(mag) * MUL_W'(scale[plcs_pkg::SCALE_W-1:HALF_W]);
    pb    <= MUL_W'(mag) * MUL_W'(scale[HALF_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_tag <= '0;
      mag_tag <= '0;
      mul_tag <= '0;
    end else begin
      sum_tag.valid <= term_tag[0].valid && term_tag[1].valid && term_tag[2].valid;
      sum_tag.axis  <= term_tag[0].axis;
      mag_tag       <= sum_tag;
      mul_tag       <= mag_tag;
    end
  end

  // magnitude * scale / 2^31, half away from zero
  always_comb begin
    bb  = {1'b0, pb} + RoundBias;
    tot = {1'b0, pa} + (bb >> HALF_W);
    r   = tot[MUL_W:15];
    nr  = -r;
    if (neg_p) begin
      val = (r >= NegMin) ? $signed(NegMin[OW-1:0]) : $signed(nr[OW-1:0]);
    end else begin
      val = (r > PosMax) ? $signed(PosMax[OW-1:0]) : $signed(r[OW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (mul_tag.valid) begin
      case (mul_tag.axis)
        plcs_pkg::AXIS_X: cur_x <= val;
        plcs_pkg::AXIS_Y: cur_y <= val;
        plcs_pkg::AXIS_Z: begin
          result.current_x <= cur_x;
          result.current_y <= cur_y;
          result.current_z <= val;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mul_tag.valid && mul_tag.axis == plcs_pkg::AXIS_Z;
    end
  end

  `PLCS_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "result strobe held for more than one cycle")
  `PLCS_ASSERT_NOW(a_lanes_aligned, clk, rst, term_tag[0].valid, term_tag[1].valid && term_tag[2].valid && term_tag[1].axis == term_tag[0].axis, "lane terms out of step")

endmodule

FILE: hw/rtl/periodic_lattice_current_stencil_unit.sv
// ----------------------------------------------------------------------------
// periodic_lattice_current_stencil_unit
// periodic cubic lattice of three complex components; loads a site or
// returns the central-difference current along x, y and z at a site
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  item      start / busy              item   (plcs_pkg::item_t)
//  result    done (one-cycle strobe)   result (plcs_pkg::result_t)
//  config    cfg_valid / cfg_ready     cfg_data (scale, Q16.16)
//
//  a load is written at its transaction and never raises busy; a query
//  holds busy after its transaction until all seven site reads are issued
//  through the single port of each component memory, and no new item is
//  taken before that; the result strobe follows through the lane and merge
//  registers, and the receiver cannot stall it
//  rst is synchronous: scale returns to 1.0, lattice contents are not cleared
//  and cfg_ready is always high
// ----------------------------------------------------------------------------
module periodic_lattice_current_stencil_unit #(
  parameter int SIDE = plcs_pkg::SIDE_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  plcs_pkg::item_t              item,
  output logic                         busy,
  output logic                         done,
  output plcs_pkg::result_t            result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [plcs_pkg::SCALE_W-1:0] cfg_data
);

  localparam int AW = $clog2(SIDE * SIDE * SIDE);

  logic mem_wr, mem_rd;
  logic [AW-1:0] mem_addr;
  plcs_pkg::rd_tag_t rd_tag;
  logic [plcs_pkg::WORD_W-1:0] wr_word [plcs_pkg::NUM_LANES];
  logic signed [plcs_pkg::TERM_W-1:0] term [plcs_pkg::NUM_LANES];
  plcs_pkg::axis_tag_t term_tag [plcs_pkg::NUM_LANES];

  assign cfg_ready = 1'b1;

  assign wr_word[0] = {item.comp0_re, item.comp0_im};
  assign wr_word[1] = {item.comp1_re, item.comp1_im};
  assign wr_word[2] = {item.comp2_re, item.comp2_im};

  plcs_seq #(.SIDE(SIDE)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .busy     (busy),
    .mem_wr   (mem_wr),
    .mem_rd   (mem_rd),
    .mem_addr (mem_addr),
    .rd_tag   (rd_tag)
  );

  for (genvar k = 0; k < plcs_pkg::NUM_LANES; k++) begin : g_lane
    plcs_lane #(.SIDE(SIDE)) u_lane (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (mem_wr),
      .rd_en    (mem_rd),
      .addr     (mem_addr),
      .wr_data  (wr_word[k]),
      .rd_tag   (rd_tag),
      .term     (term[k]),
      .term_tag (term_tag[k])
    );
  end

  plcs_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .term     (term),
    .term_tag (term_tag),
    .done     (done),
    .result   (result)
  );

endmodule
